[design/sliding_window_median_filter_defines.svh]
// Assertion macros shared by the sliding window median filter RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWMF_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWMF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/swmf_pkg.sv]
// Shared types and constants of the sliding window median filter.
// No dependencies; used by swmf_cell and sliding_window_median_filter.
`default_nettype none

package swmf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE     = 2'd0,
        REG_WIN_LEN    = 2'd1,
        REG_FILL_VALUE = 2'd2
    } cfg_reg_e;

    // Broadcast control seen by every cell of the sorted chain.
    typedef struct packed {
        logic    shift;       // insert x, evict the oldest entry
        logic    fill;        // load fill_value into every cell
        sample_t x;           // sample being inserted
        sample_t fill_value;  // value used by a refill
    } cell_ctrl_t;

endpackage

`default_nettype wire

[design/swmf_cell.sv]
// One cell of the sorted median chain: holds a value and its age tag.
// Depends on swmf_pkg for sample_t and cell_ctrl_t.
`default_nettype none

module swmf_cell
    import swmf_pkg::*;
#(
    parameter int AGE_W = 4
)
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic             active,
    input  logic [AGE_W-1:0] last_age,
    input  logic [AGE_W-1:0] fill_age,
    input  sample_t          prev_value,
    input  logic [AGE_W-1:0] prev_age,
    input  logic             prev_le,
    input  logic             prev_b,
    input  logic             self_b,
    input  sample_t          next_value,
    input  logic [AGE_W-1:0] next_age,
    input  logic             next_le,
    output sample_t          value,
    output logic [AGE_W-1:0] age,
    output logic             le,
    output logic             del
);

    sample_t          value_reg;
    sample_t          value_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    logic             keep_low;
    logic             above;

    assign le  = active && (value_reg <= ctrl.x);
    assign del = active && (age_reg == last_age);

    // The surviving entry at this slot is still at or below the new sample.
    assign keep_low = self_b ? next_le : le;
    // The surviving entry one slot down is already above the new sample.
    assign above    = prev_b ? !le : !prev_le;

    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.fill)
        begin
            value_next = ctrl.fill_value;
            age_next   = fill_age;
        end
        else if (ctrl.shift)
        begin
            if (keep_low)
            begin
                value_next = self_b ? next_value : value_reg;
                age_next   = (self_b ? next_age : age_reg) + AGE_W'(1);
            end
            else if (above)
            begin
                value_next = prev_b ? value_reg : prev_value;
                age_next   = (prev_b ? age_reg : prev_age) + AGE_W'(1);
            end
            else
            begin
                value_next = ctrl.x;
                age_next   = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign value = value_reg;
    assign age   = age_reg;

endmodule

`default_nettype wire

[design/sliding_window_median_filter.sv]
// Sliding window median filter, top level.
// Depends on swmf_pkg, swmf_cell and sliding_window_median_filter_defines.svh.
//
// Input channel (in_valid, in_stall, sample) takes one signed sample per transfer;
// output channel (out_valid, out_stall, filtered) returns one result per sample:
// the median of the last window-length samples (upper middle value for an even
// length), or the sample itself while enable is 0. Configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) writes enable, the window length and the fill
// value; every effective write refills the window with the fill value, and a
// length outside 1..MAX_WINDOW is dropped.
// The window is a chain of MAX_WINDOW cells kept in ascending order with age tags.
// A filtered sample evicts the oldest cell and is inserted at its sorted place at
// its own transfer edge and marked pending; once the output register is free, the
// median is loaded into it and out_valid rises. Throughput is one sample
// per cycle while the receiver takes results. When out_stall holds a result, one
// more sample may enter and wait in the chain; then in_stall rises until the output
// register drains. Reset sets enable=0, a window length of 3 and a fill value of 0
// and empties the output; the cells hold no defined contents until the first
// configuration write.
`default_nettype none
`include "sliding_window_median_filter_defines.svh"

module sliding_window_median_filter
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sample_t                sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sample_t                filtered,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int WS_W  = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // Configuration registers.
    logic            enable_reg;
    logic            enable_next;
    logic [WS_W-1:0] win_len_reg;
    logic [WS_W-1:0] win_len_next;
    sample_t         init_value_reg;
    sample_t         init_value_next;
    logic            refill;
    logic [WS_W-1:0] ws_in;

    // Handshake and result staging.
    logic    in_accept;
    logic    cfg_accept;
    logic    pend_reg;
    logic    pend_next;
    logic    bypass_reg;
    sample_t bypass_value_reg;
    logic    out_valid_reg;
    sample_t out_data_reg;
    logic    out_free;
    logic    move;

    // Cell chain.
    cell_ctrl_t       ctrl;
    sample_t          cell_value [MAX_WINDOW];
    logic [AGE_W-1:0] cell_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] cell_le;
    logic [MAX_WINDOW-1:0] cell_del;
    logic [MAX_WINDOW-1:0] del_below;
    logic [AGE_W-1:0] last_age;
    logic [WS_W-1:0]  half_size;
    logic [AGE_W-1:0] mid_idx;
    sample_t          median;

    assign in_accept  = in_valid && !in_stall;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_ready  = !pend_reg;
    assign ws_in      = cfg_data[WS_W-1:0];

    // Configuration decode; any effective write triggers a refill.
    always_comb
    begin
        enable_next     = enable_reg;
        win_len_next    = win_len_reg;
        init_value_next = init_value_reg;
        refill          = 1'b0;
        if (cfg_accept)
        begin
            case (cfg_index)
                REG_ENABLE:
                begin
                    enable_next = cfg_data[0];
                    refill      = 1'b1;
                end
                REG_WIN_LEN:
                begin
                    if ((ws_in >= WS_W'(1)) && (ws_in <= WS_W'(MAX_WINDOW)))
                    begin
                        win_len_next = ws_in;
                        refill       = 1'b1;
                    end
                end
                REG_FILL_VALUE:
                begin
                    init_value_next = sample_t'(cfg_data[SAMPLE_W-1:0]);
                    refill          = 1'b1;
                end
                default:
                begin
                    refill = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            win_len_reg    <= WS_W'(3);
            init_value_reg <= '0;
        end
        else
        begin
            enable_reg     <= enable_next;
            win_len_reg    <= win_len_next;
            init_value_reg <= init_value_next;
        end
    end

    assign ctrl.shift      = in_accept && enable_reg;
    assign ctrl.fill       = refill;
    assign ctrl.x          = sample;
    assign ctrl.fill_value = init_value_next;

    assign last_age = AGE_W'(win_len_reg - WS_W'(1));

    // The chain itself. del_below[k] marks an eviction at or below slot k.
    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        logic [WS_W-1:0]  fill_age_w;
        logic             active;
        sample_t          prev_value;
        logic [AGE_W-1:0] prev_age;
        logic             prev_le;
        logic             prev_b;
        sample_t          next_value;
        logic [AGE_W-1:0] next_age;
        logic             next_le;

        // After a refill the lowest slot is the oldest entry.
        assign fill_age_w   = win_len_next - WS_W'(1) - WS_W'(k);
        assign active       = win_len_reg > WS_W'(k);
        assign del_below[k] = |cell_del[k:0];

        if (k == 0)
        begin : g_first
            assign prev_value = '0;
            assign prev_age   = '0;
            assign prev_le    = 1'b1;
            assign prev_b     = 1'b0;
        end
        else
        begin : g_inner_prev
            assign prev_value = cell_value[k-1];
            assign prev_age   = cell_age[k-1];
            assign prev_le    = cell_le[k-1];
            assign prev_b     = del_below[k-1];
        end

        if (k == MAX_WINDOW - 1)
        begin : g_last
            assign next_value = '0;
            assign next_age   = '0;
            assign next_le    = 1'b0;
        end
        else
        begin : g_inner_next
            assign next_value = cell_value[k+1];
            assign next_age   = cell_age[k+1];
            assign next_le    = cell_le[k+1];
        end

        swmf_cell #(
            .AGE_W (AGE_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .active     (active),
            .last_age   (last_age),
            .fill_age   (fill_age_w[AGE_W-1:0]),
            .prev_value (prev_value),
            .prev_age   (prev_age),
            .prev_le    (prev_le),
            .prev_b     (prev_b),
            .self_b     (del_below[k]),
            .next_value (next_value),
            .next_age   (next_age),
            .next_le    (next_le),
            .value      (cell_value[k]),
            .age        (cell_age[k]),
            .le         (cell_le[k]),
            .del        (cell_del[k])
        );
    end

    // The median sits at slot (window length)/2 of the sorted chain.
    assign half_size = win_len_reg >> 1;
    assign mid_idx   = half_size[AGE_W-1:0];
    assign median    = cell_value[mid_idx];

    // A pending result moves into the output register once it is free.
    assign out_free  = !out_valid_reg || !out_stall;
    assign move      = pend_reg && out_free;
    assign in_stall  = pend_reg && !out_free;
    assign pend_next = in_accept || (pend_reg && !move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            bypass_reg       <= !enable_reg;
            bypass_value_reg <= sample;
        end
        if (move)
        begin
            out_data_reg <= bypass_reg ? bypass_value_reg : median;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = out_data_reg;

    // A filtered sample always evicts exactly one live cell.
    `SWMF_ASSERT_NOW(a_one_eviction, ctrl.shift, $onehot(cell_del), "eviction is not one-hot")
    // A pending result always reaches the output register.
    `SWMF_ASSERT_NEXT(a_move_fills_out, move, out_valid_reg, "pending result lost")
    // A sample taken while disabled is staged as a pass-through result.
    `SWMF_ASSERT_NEXT(a_bypass_staged, in_accept && !enable_reg, pend_reg && bypass_reg,
        "pass-through sample not staged")

endmodule

`default_nettype wire

[dv/swmf_checker.sv]
// Checker for the sliding window median filter: watches the register, sample and result
// channels, predicts each result and compares it. Depends on swmf_pkg.
`default_nettype none

module swmf_checker
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire sample_t                sample,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire sample_t                filtered,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned                 mismatches,
    output int unsigned                 backlog
);

    // Shadow copy of the registers and of the window ring.
    logic        en_q;
    logic [4:0]  size_q;
    sample_t     fill_q;
    sample_t     ring [MAX_WINDOW];
    int unsigned head;
    sample_t     medians_due [$];
    sample_t     want;

    task automatic report(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic refill();
        foreach (ring[k])
            ring[k] = fill_q;
        head = 0;
    endtask

    task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ENABLE:
            begin
                en_q = data[0];
                refill();
            end
            REG_WIN_LEN:
            begin
                if (data[4:0] >= 5'd1 && data[4:0] <= 5'(MAX_WINDOW))
                begin
                    size_q = data[4:0];
                    refill();
                end
            end
            REG_FILL_VALUE:
            begin
                fill_q = sample_t'(data);
                refill();
            end
            default:
            begin
            end
        endcase
    endtask

    // The median is the entry with at most half the window strictly below it
    // and more than half at or below it; for an even window that is the upper one.
    function automatic sample_t window_median();
        int unsigned n;
        int unsigned half;
        int unsigned below;
        int unsigned at_or_below;
        n    = size_q;
        half = n / 2;
        for (int i = 0; i < n; i++)
        begin
            below       = 0;
            at_or_below = 0;
            for (int j = 0; j < n; j++)
            begin
                if (ring[j] < ring[i])
                    below++;
                if (ring[j] <= ring[i])
                    at_or_below++;
            end
            if (below <= half && half < at_or_below)
                return ring[i];
        end
        return ring[0];
    endfunction

    function automatic sample_t next_median(input sample_t s);
        if (!en_q)
            return s;
        ring[head] = s;
        head = (head + 1 >= size_q) ? 0 : head + 1;
        return window_median();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_q   = 1'b0;
            size_q = 5'd3;
            fill_q = '0;
            head   = 0;
            foreach (ring[k])
                ring[k] = '0;
            medians_due.delete();
            mismatches = 0;
            backlog    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (medians_due.size() == 0)
                    report($sformatf("result %0d with no sample outstanding", filtered));
                else
                begin
                    want = medians_due.pop_front();
                    if (filtered !== want)
                        report($sformatf("filtered %0d, predicted %0d", filtered, want));
                end
            end
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                medians_due.push_back(next_median(sample));
            backlog = medians_due.size();
        end
    end

endmodule

`default_nettype wire

[dv/tb_sliding_window_median_filter.sv]
// Top of the sliding window median filter testbench: clock, reset, stimulus and verdict.
// Depends on swmf_pkg, the sliding_window_median_filter RTL and swmf_checker.
`default_nettype none

module tb_sliding_window_median_filter;
    import swmf_pkg::*;

    // Index past the end of the register list; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    sample_t                sample    = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    sample_t                filtered;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int unsigned mismatches;
    int unsigned backlog;

    // Shared between the stimulus and the result-side process.
    logic quiet    = 1'b0;   // no random idling on either side while set
    logic hold_req = 1'b0;   // asks the receiver for one long hold-off

    // Run statistics for the closing summary.
    int unsigned samples_sent   = 0;
    int unsigned median_samples = 0;
    int unsigned reg_writes     = 0;
    logic        en_shadow      = 1'b0;

    sliding_window_median_filter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    swmf_checker median_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .filtered   (filtered),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Result side. Normally it stalls at random, 7 times in 100. On request it holds
    // off for a long stretch so the chain and output register fill and the block
    // has to push back on its input.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 80;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 7);
        end
    end

    // Offers one sample and returns once the transfer has happened. Valid is left
    // high so that back-to-back samples never drop it between transfers; a random
    // gap, when taken, lowers it first.
    task automatic send(input sample_t s);
        if (!quiet && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        samples_sent++;
        if (en_shadow)
            median_samples++;
    endtask

    // Stops offering samples and waits until every outstanding result has been taken,
    // then lets the two-stage pipeline go quiet. The first edge makes sure a transfer
    // at the current edge is already counted by the checker.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes happen only with the block idle, so each one drains first.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == REG_ENABLE)
            en_shadow = data[0];
    endtask

    initial
    begin
        int unsigned count;
        int unsigned pick;
        logic [4:0]  size;
        sample_t     fill;
        sample_t     s;
        logic        on;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the filter is off: every sample, extremes and alternating
        // bit patterns included, must come back unchanged.
        send(16'sh7fff);
        send(16'sh8000);
        send(16'sh0000);
        send(16'shffff);
        send(16'sh5555);
        send(16'shaaaa);

        // Turning the filter on refills the default three-entry window with zeros.
        write_reg(REG_ENABLE, 16'd1);
        send(16'sd5);
        send(16'sh8000);
        send(16'sh7fff);
        send(16'sd7);

        // Out-of-range window sizes are dropped whole: no refill, size stays at three.
        write_reg(REG_WIN_LEN, 16'd0);
        send(-16'sd3);
        write_reg(REG_WIN_LEN, 16'd17);
        write_reg(REG_WIN_LEN, 16'd31);
        send(16'sd9);

        // A write past the register list is a no-op as well.
        write_reg(REG_UNUSED, 16'hffff);
        send(16'sd2);

        // Even window: the upper of the two middle values wins.
        write_reg(REG_WIN_LEN, 16'd2);
        send(16'sd10);
        send(-16'sd10);
        send(16'sd4);

        // Single-entry window passes each sample through the median path.
        write_reg(REG_WIN_LEN, 16'd1);
        send(16'sh8000);
        send(16'sh7fff);

        // Largest window, filled with the most negative value.
        write_reg(REG_FILL_VALUE, 16'h8000);
        write_reg(REG_WIN_LEN, 16'd16);
        send(16'sh7fff);
        send(16'sd0);
        send(16'sh7ffe);

        // Disabling after filtering goes back to pass-through.
        write_reg(REG_ENABLE, 16'd0);
        send(-16'sd77);

        // Random phases, each with its own settings. The first two pin the window to
        // its extremes; phase 3 runs with no idling at all, phase 5 holds off the
        // receiver for a long stretch, phase 6 runs disabled and phase 7 pauses the
        // sender mid-stream until every result is back.
        for (int phase = 0; phase < 13; phase++)
        begin
            quiet = (phase == 3);
            if (phase == 0)
                size = 5'd16;
            else if (phase == 1)
                size = 5'd1;
            else
                size = 5'($urandom_range(1, 16));
            case ($urandom_range(3))
                0: fill = 16'sh8000;
                1: fill = 16'sh7fff;
                default: fill = sample_t'($urandom);
            endcase
            on = (phase == 6) ? 1'b0 : ($urandom_range(9) != 0);

            if ($urandom_range(4) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            if ($urandom_range(3) == 0)
                write_reg(REG_WIN_LEN,
                          $urandom_range(1) ? 16'd0 : CFG_DATA_W'($urandom_range(17, 31)));
            if ($urandom_range(1))
            begin
                write_reg(REG_FILL_VALUE, fill);
                write_reg(REG_WIN_LEN, CFG_DATA_W'(size));
            end
            else
            begin
                write_reg(REG_WIN_LEN, CFG_DATA_W'(size));
                write_reg(REG_FILL_VALUE, fill);
            end
            write_reg(REG_ENABLE, CFG_DATA_W'(on));

            count = 55 + $urandom_range(10);
            for (int i = 0; i < count; i++)
            begin
                if (phase == 5 && i == 10)
                    hold_req = 1'b1;
                if (phase == 7 && i == 30)
                    settle();
                // Mix of full-range values, a narrow band that produces many ties,
                // the extremes, and values just around the fill value so that
                // leftover fill entries compete with new samples.
                pick = $urandom_range(19);
                if (pick < 8)
                    s = sample_t'($urandom);
                else if (pick < 14)
                    s = sample_t'($urandom_range(8)) - sample_t'(4);
                else if (pick < 17)
                begin
                    case ($urandom_range(3))
                        0: s = 16'sh7fff;
                        1: s = 16'sh8000;
                        2: s = '0;
                        default: s = '1;
                    endcase
                end
                else
                    s = fill + sample_t'($urandom_range(4)) - sample_t'(2);
                send(s);
            end
        end
        quiet = 1'b0;

        settle();
        repeat (8) @(posedge clk);

        $display("Covered %0d samples, %0d of them through the median path,",
                 samples_sent, median_samples);
        $display("and %0d register writes over window sizes 1 to 16, with stalls, %s",
                 reg_writes, "a long hold-off and a mid-stream drain.");
        if (mismatches == 0 && backlog == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
